/* sv/jrw_pkg.sv */
// Shared types, constants and weight table for the joint range window filter.
// No dependencies; used by every module of the block except the line store.
package jrw_pkg;

  localparam int LANES        = 3;
  localparam int SAMPLE_W     = 16;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int QUO_W        = 17;
  localparam int DIFF_W       = 18;
  localparam int DECAY_W      = 24;
  localparam int EXP_W        = DIFF_W + DECAY_W;
  localparam int WT_W         = 17;
  localparam int PROD_W       = 34;
  localparam int CFG_AW       = 5;
  localparam int WORD_W       = 2 * LANES * SAMPLE_W;
  localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [QUO_W-1:0] MAG_LIMIT = 17'd32768;

  localparam logic [10:0] RESET_WIDTH  = 11'd640;
  localparam logic [12:0] RESET_HEIGHT = 13'd480;
  localparam logic [1:0]  RESET_RADIUS = 2'd1;
  localparam logic [1:0]  RESET_CHAN   = 2'd1;
  localparam logic [23:0] RESET_DECAY  = 24'd94548;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_WINDOW_RADIUS,
    REG_GUIDE_CHANNELS,
    REG_SIGNAL_CHANNELS,
    REG_DECAY_RATE
  } reg_index_t;

  typedef struct packed {
    logic valid;
    logic centre;
    logic use_tap;
    logic last;
  } tap_t;

  localparam logic [WT_W-1:0] FRAC_ROM [64] = '{
    17'd65536, 17'd64830, 17'd64132, 17'd63441, 17'd62757, 17'd62081, 17'd61413, 17'd60751,
    17'd60097, 17'd59449, 17'd58809, 17'd58176, 17'd57549, 17'd56929, 17'd56316, 17'd55709,
    17'd55109, 17'd54515, 17'd53928, 17'd53347, 17'd52773, 17'd52204, 17'd51642, 17'd51085,
    17'd50535, 17'd49991, 17'd49452, 17'd48920, 17'd48393, 17'd47871, 17'd47356, 17'd46846,
    17'd46341, 17'd45842, 17'd45348, 17'd44859, 17'd44376, 17'd43898, 17'd43425, 17'd42958,
    17'd42495, 17'd42037, 17'd41584, 17'd41136, 17'd40693, 17'd40255, 17'd39821, 17'd39392,
    17'd38968, 17'd38548, 17'd38133, 17'd37722, 17'd37316, 17'd36914, 17'd36516, 17'd36123,
    17'd35734, 17'd35349, 17'd34968, 17'd34591, 17'd34219, 17'd33850, 17'd33486, 17'd33125
  };

endpackage

/* sv/jrw_line_store.sv */
// Line store: one synchronous RAM holding guide and sample words of recent rows.
// One write port, one read port with registered read data. No package use.
module jrw_line_store #(
  parameter int DEPTH  = 7168,
  parameter int ADDR_W = 13,
  parameter int DATA_W = 96
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/jrw_window_accum.sv */
// Window accumulator: guide distance, range weight, products and running sums.
// Depends on jrw_pkg for the tap struct, widths and the fraction table.
module jrw_window_accum #(
  parameter int ACC_W  = 39,
  parameter int WSUM_W = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  jrw_pkg::tap_t             tap,
  input  logic [jrw_pkg::WORD_W-1:0] rdata,
  input  logic [jrw_pkg::DECAY_W-1:0] decay_rate,
  input  logic [1:0]                gc,
  output logic                      acc_done,
  output logic signed [ACC_W-1:0]   acc [jrw_pkg::LANES],
  output logic [WSUM_W-1:0]         wsum
);

  logic [15:0] g [jrw_pkg::LANES];
  logic [15:0] cg [jrw_pkg::LANES];
  logic [jrw_pkg::DIFF_W-1:0] d;

  jrw_pkg::tap_t a_tap, b_tap, c_tap, d_tap;
  logic [jrw_pkg::DIFF_W-1:0] a_d;
  logic signed [15:0] a_s [jrw_pkg::LANES];
  logic signed [15:0] b_s [jrw_pkg::LANES];
  logic signed [15:0] c_s [jrw_pkg::LANES];
  logic [jrw_pkg::EXP_W-1:0] b_e;
  logic [jrw_pkg::WT_W-1:0] wt, c_wt, d_wt;
  logic signed [jrw_pkg::PROD_W-1:0] d_p [jrw_pkg::LANES];
  logic [jrw_pkg::EXP_W-17:0] whole;

  always_comb begin
    d = '0;
    for (int i = 0; i < jrw_pkg::LANES; i++) begin
      g[i] = rdata[16*i +: 16];
      if (i < 32'(gc)) begin
        if (g[i] > cg[i]) d = d + jrw_pkg::DIFF_W'(g[i] - cg[i]);
        else              d = d + jrw_pkg::DIFF_W'(cg[i] - g[i]);
      end
    end
  end

  assign whole = b_e[jrw_pkg::EXP_W-1:16];

  always_comb begin
    if (b_tap.centre) begin
      wt = jrw_pkg::ONE_Q16;
    end else if (!b_tap.use_tap || whole > 16) begin
      wt = '0;
    end else begin
      wt = jrw_pkg::FRAC_ROM[b_e[15:10]] >> whole[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tap    <= '0;
      b_tap    <= '0;
      c_tap    <= '0;
      d_tap    <= '0;
      acc_done <= 1'b0;
    end else begin
      a_tap    <= tap;
      b_tap    <= a_tap;
      c_tap    <= b_tap;
      d_tap    <= c_tap;
      acc_done <= d_tap.valid && d_tap.last;
    end
  end

  always_ff @(posedge clk) begin
    if (tap.valid && tap.centre) begin
      for (int i = 0; i < jrw_pkg::LANES; i++) cg[i] <= g[i];
    end
    a_d <= d;
    b_e <= jrw_pkg::EXP_W'(a_d) * jrw_pkg::EXP_W'(decay_rate);
    c_wt <= wt;
    d_wt <= c_wt;
    for (int i = 0; i < jrw_pkg::LANES; i++) begin
      a_s[i] <= tap.use_tap ? $signed(rdata[48+16*i +: 16]) : '0;
      b_s[i] <= a_s[i];
      c_s[i] <= b_s[i];
      d_p[i] <= c_s[i] * $signed({1'b0, c_wt});
    end
    if (d_tap.valid) begin
      if (d_tap.centre) begin
        wsum <= WSUM_W'(d_wt);
        for (int i = 0; i < jrw_pkg::LANES; i++) acc[i] <= ACC_W'(d_p[i]);
      end else begin
        wsum <= wsum + WSUM_W'(d_wt);
        for (int i = 0; i < jrw_pkg::LANES; i++) acc[i] <= acc[i] + ACC_W'(d_p[i]);
      end
    end
  end

endmodule

/* sv/jrw_divide.sv */
// Rounding divider: three restoring lanes sharing one shifted weight-sum divisor.
// Depends on jrw_pkg for lane count and quotient width.
module jrw_divide #(
  parameter int ACC_W  = 39,
  parameter int WSUM_W = 23
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] acc [jrw_pkg::LANES],
  input  logic [WSUM_W-1:0]       wsum,
  input  logic [1:0]              sc,
  output logic                    done,
  output logic [15:0]             result [jrw_pkg::LANES]
);

  localparam int RW = (ACC_W + 1 > WSUM_W + jrw_pkg::QUO_W) ? ACC_W + 1
                                                            : WSUM_W + jrw_pkg::QUO_W;
  localparam int CNT_W = $clog2(jrw_pkg::QUO_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [RW-1:0]             dsh;
  logic                      neg [jrw_pkg::LANES];
  logic [RW-1:0]             rem [jrw_pkg::LANES];
  logic [jrw_pkg::QUO_W-1:0] quo [jrw_pkg::LANES];
  logic [ACC_W-1:0]          mag [jrw_pkg::LANES];
  logic [jrw_pkg::QUO_W-1:0] qc  [jrw_pkg::LANES];

  always_comb begin
    for (int i = 0; i < jrw_pkg::LANES; i++) begin
      mag[i] = acc[i][ACC_W-1] ? ACC_W'(-acc[i]) : ACC_W'(acc[i]);
      qc[i]  = (quo[i] > jrw_pkg::MAG_LIMIT) ? jrw_pkg::MAG_LIMIT : quo[i];
      if (i >= 32'(sc))  result[i] = '0;
      else if (neg[i])   result[i] = 16'(-qc[i]);
      else if (qc[i] > jrw_pkg::QUO_W'(32767)) result[i] = 16'h7fff;
      else               result[i] = qc[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dsh  <= RW'(wsum) << jrw_pkg::QUO_W;
        for (int i = 0; i < jrw_pkg::LANES; i++) begin
          neg[i] <= acc[i][ACC_W-1];
          rem[i] <= (RW'(mag[i]) << 1) + RW'(wsum);
          quo[i] <= '0;
        end
      end else if (busy) begin
        dsh <= dsh >> 1;
        cnt <= cnt + CNT_W'(1);
        for (int i = 0; i < jrw_pkg::LANES; i++) begin
          if (rem[i] >= dsh) begin
            rem[i] <= rem[i] - dsh;
            quo[i] <= {quo[i][jrw_pkg::QUO_W-2:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][jrw_pkg::QUO_W-2:0], 1'b0};
          end
        end
        if (cnt == CNT_W'(jrw_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/joint_range_window_filter.sv */
// A pixel is accepted in S_IDLE, checked in S_CHECK1 and decided in S_CHECK2; a flush with
// nothing pending is ignored in S_IDLE. An output adds a centre read, (2r+1)^2 window reads
// (one line-store read per cycle), the accumulator pipeline, the divider and the output load;
// an emitting flush skips the pixel checks. One item is in work at a time; a finished result
// waits in the output register. Synchronous reset restores register defaults and clears
// counters; line store contents are left undefined until written.
module joint_range_window_filter #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_RADIUS   = 3,
  parameter int MAX_CHANNELS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jrw_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                guide_a,
  input  logic [15:0]                guide_b,
  input  logic [15:0]                guide_c,
  input  logic signed [15:0]         sample_a,
  input  logic signed [15:0]         sample_b,
  input  logic signed [15:0]         sample_c,
  input  logic                       is_flush,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [15:0]         smoothed_a,
  output logic signed [15:0]         smoothed_b,
  output logic signed [15:0]         smoothed_c,
  output logic                       frame_done
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int SLOTS  = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DEPTH  = SLOTS * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int OFS_W  = RAD_W + 1;
  localparam int WIN_N  = SLOTS * SLOTS;
  localparam int ACC_W  = 33 + $clog2(WIN_N);
  localparam int WSUM_W = 17 + $clog2(WIN_N);
  localparam int ROW_W  = jrw_pkg::ROW_W;
  localparam int POS_W  = ROW_W + WW;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK1, S_CHECK2, S_START, S_SCAN, S_DRAIN, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [1:0]  cfg_radius, cfg_gc, cfg_sc;
  logic [23:0] cfg_decay;

  logic [WW-1:0]                  eff_w;
  logic [jrw_pkg::HEIGHT_W-1:0]   eff_h;
  logic [RAD_W-1:0]               eff_r;
  logic [1:0]                     eff_gc, eff_sc;

  logic [COL_W-1:0]  in_col, out_col, pos_col, c_col;
  logic [ROW_W-1:0]  in_row, out_row, pos_row, c_row;
  logic [SLOT_W-1:0] in_slot, out_slot, c_slot;
  logic              input_full, c_done;
  logic [POS_W-1:0]  p_pos, q_pos, lag;
  logic signed [OFS_W-1:0] dx, dy;

  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  logic scan_last;
  logic signed [SLOT_W+1:0] nslot;
  logic signed [COL_W+1:0]  nx;
  logic signed [ROW_W+1:0]  ny;
  logic                     nb_in;
  logic [AW-1:0]            nb_addr, centre_addr, wr_addr, rd_addr;
  logic                     wr_en, rd_en;
  logic [jrw_pkg::WORD_W-1:0] rd_data;
  jrw_pkg::tap_t            tap_issue, tap;

  logic                    acc_done, div_start, div_done;
  logic signed [ACC_W-1:0] acc [jrw_pkg::LANES];
  logic [WSUM_W-1:0]       wsum;
  logic [15:0]             result [jrw_pkg::LANES];

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    if (cfg_width == '0)                eff_w = WW'(1);
    else if (32'(cfg_width) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else                                 eff_w = WW'(cfg_width);
    if (cfg_height == '0) eff_h = jrw_pkg::HEIGHT_W'(1);
    else if (32'(cfg_height) > jrw_pkg::HEIGHT_LIMIT)
      eff_h = jrw_pkg::HEIGHT_W'(jrw_pkg::HEIGHT_LIMIT);
    else eff_h = cfg_height;
    if (cfg_radius == '0)                 eff_r = RAD_W'(1);
    else if (32'(cfg_radius) > MAX_RADIUS) eff_r = RAD_W'(MAX_RADIUS);
    else                                   eff_r = RAD_W'(cfg_radius);
    if (cfg_gc == '0)                     eff_gc = 2'd1;
    else if (32'(cfg_gc) > MAX_CHANNELS)  eff_gc = 2'(MAX_CHANNELS);
    else                                  eff_gc = cfg_gc;
    if (cfg_sc == '0)                     eff_sc = 2'd1;
    else if (32'(cfg_sc) > MAX_CHANNELS)  eff_sc = 2'(MAX_CHANNELS);
    else                                  eff_sc = cfg_sc;
  end

  always_comb begin
    case (paddr[4:2])
      jrw_pkg::REG_FRAME_WIDTH:     prdata = 32'(cfg_width);
      jrw_pkg::REG_FRAME_HEIGHT:    prdata = 32'(cfg_height);
      jrw_pkg::REG_WINDOW_RADIUS:   prdata = 32'(cfg_radius);
      jrw_pkg::REG_GUIDE_CHANNELS:  prdata = 32'(cfg_gc);
      jrw_pkg::REG_SIGNAL_CHANNELS: prdata = 32'(cfg_sc);
      jrw_pkg::REG_DECAY_RATE:      prdata = 32'(cfg_decay);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= jrw_pkg::RESET_WIDTH;
      cfg_height <= jrw_pkg::RESET_HEIGHT;
      cfg_radius <= jrw_pkg::RESET_RADIUS;
      cfg_gc     <= jrw_pkg::RESET_CHAN;
      cfg_sc     <= jrw_pkg::RESET_CHAN;
      cfg_decay  <= jrw_pkg::RESET_DECAY;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        jrw_pkg::REG_FRAME_WIDTH:     cfg_width  <= pwdata[10:0];
        jrw_pkg::REG_FRAME_HEIGHT:    cfg_height <= pwdata[12:0];
        jrw_pkg::REG_WINDOW_RADIUS:   cfg_radius <= pwdata[1:0];
        jrw_pkg::REG_GUIDE_CHANNELS:  cfg_gc     <= pwdata[1:0];
        jrw_pkg::REG_SIGNAL_CHANNELS: cfg_sc     <= pwdata[1:0];
        jrw_pkg::REG_DECAY_RATE:      cfg_decay  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  assign in_col_wrap  = (32'(in_col) + 1 >= 32'(eff_w));
  assign in_row_wrap  = (32'(in_row) + 1 >= 32'(eff_h));
  assign out_col_wrap = (32'(out_col) + 1 >= 32'(eff_w));
  assign out_row_wrap = (32'(out_row) + 1 >= 32'(eff_h));

  always_comb begin
    nslot = $signed({2'b00, c_slot}) + (SLOT_W+2)'(dy);
    if (nslot < 0)                              nslot = nslot + (SLOT_W+2)'(SLOTS);
    else if (nslot >= $signed((SLOT_W+2)'(SLOTS))) nslot = nslot - (SLOT_W+2)'(SLOTS);
    nx = $signed({2'b00, c_col}) + (COL_W+2)'(dx);
    ny = $signed({2'b00, c_row}) + (ROW_W+2)'(dy);
    nb_in = !nx[COL_W+1] && (nx < $signed((COL_W+2)'(eff_w))) &&
            !ny[ROW_W+1] && (ny < $signed((ROW_W+2)'(eff_h))) &&
            !(dx == '0 && dy == '0);
    nb_addr     = AW'(32'(nslot[SLOT_W-1:0]) * MAX_WIDTH + 32'(nx[COL_W-1:0]));
    centre_addr = AW'(32'(out_slot) * MAX_WIDTH + 32'(out_col));
    scan_last   = (dx == OFS_W'(eff_r)) && (dy == OFS_W'(eff_r));
  end

  assign wr_en   = (state == S_IDLE) && in_valid && !is_flush;
  assign wr_addr = AW'(32'(in_slot) * MAX_WIDTH + 32'(in_col));
  assign rd_en   = (state == S_START) || (state == S_SCAN);
  assign rd_addr = (state == S_START) ? centre_addr : nb_addr;

  always_comb begin
    tap_issue.valid   = rd_en;
    tap_issue.centre  = (state == S_START);
    tap_issue.use_tap = (state == S_START) || nb_in;
    tap_issue.last    = (state == S_SCAN) && scan_last;
  end

  assign div_start = (state == S_DRAIN) && acc_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tap        <= '0;
      out_valid  <= 1'b0;
      input_full <= 1'b0;
      in_col     <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_slot   <= '0;
    end else begin
      tap <= tap_issue;
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (is_flush) begin
              if (input_full) state <= S_START;
            end else begin
              if (input_full) begin
                out_col  <= '0;
                out_row  <= '0;
                out_slot <= '0;
              end
              pos_col <= in_col;
              pos_row <= in_row;
              input_full <= in_col_wrap && in_row_wrap;
              if (in_col_wrap) begin
                in_col <= '0;
                if (in_row_wrap) begin
                  in_row  <= '0;
                  in_slot <= '0;
                end else begin
                  in_row  <= in_row + ROW_W'(1);
                  in_slot <= (in_slot == SLOT_W'(SLOTS - 1)) ? '0 : in_slot + SLOT_W'(1);
                end
              end else begin
                in_col <= in_col + COL_W'(1);
              end
              state <= S_CHECK1;
            end
          end
        end
        S_CHECK1: begin
          p_pos <= POS_W'(pos_row) * POS_W'(eff_w) + POS_W'(pos_col);
          q_pos <= POS_W'(out_row) * POS_W'(eff_w) + POS_W'(out_col);
          lag   <= POS_W'(eff_r) * POS_W'(eff_w) + POS_W'(eff_r);
          state <= S_CHECK2;
        end
        S_CHECK2: begin
          if ((POS_W+1)'(q_pos) + (POS_W+1)'(lag) <= (POS_W+1)'(p_pos)) state <= S_START;
          else                                                       state <= S_IDLE;
        end
        S_START: begin
          c_col  <= out_col;
          c_row  <= out_row;
          c_slot <= out_slot;
          c_done <= out_col_wrap && out_row_wrap;
          if (out_col_wrap && out_row_wrap) input_full <= 1'b0;
          if (out_col_wrap) begin
            out_col <= '0;
            if (out_row_wrap) begin
              out_row  <= '0;
              out_slot <= '0;
            end else begin
              out_row  <= out_row + ROW_W'(1);
              out_slot <= (out_slot == SLOT_W'(SLOTS - 1)) ? '0 : out_slot + SLOT_W'(1);
            end
          end else begin
            out_col <= out_col + COL_W'(1);
          end
          dx    <= OFS_W'(0) - OFS_W'(eff_r);
          dy    <= OFS_W'(0) - OFS_W'(eff_r);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_DRAIN;
          end else if (dx == OFS_W'(eff_r)) begin
            dx <= OFS_W'(0) - OFS_W'(eff_r);
            dy <= dy + OFS_W'(1);
          end else begin
            dx <= dx + OFS_W'(1);
          end
        end
        S_DRAIN: begin
          if (acc_done) state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            smoothed_a <= $signed(result[0]);
            smoothed_b <= $signed(result[1]);
            smoothed_c <= $signed(result[2]);
            frame_done <= c_done;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  jrw_line_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (jrw_pkg::WORD_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({sample_c, sample_b, sample_a, guide_c, guide_b, guide_a}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  jrw_window_accum #(
    .ACC_W  (ACC_W),
    .WSUM_W (WSUM_W)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .tap        (tap),
    .rdata      (rd_data),
    .decay_rate (cfg_decay),
    .gc         (eff_gc),
    .acc_done   (acc_done),
    .acc        (acc),
    .wsum       (wsum)
  );

  jrw_divide #(
    .ACC_W  (ACC_W),
    .WSUM_W (WSUM_W)
  ) u_divide (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .acc    (acc),
    .wsum   (wsum),
    .sc     (eff_sc),
    .done   (div_done),
    .result (result)
  );

  a_acc_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == S_DRAIN)
    else $error("window sums finished outside drain");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_store_port: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("line store write and read in the same cycle");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("output transaction raised outside load state");

endmodule
